// File: src/checksummed_frame_builder_core_macros.svh
// Assertion macros shared by the frame builder checker.
`ifndef CHECKSUMMED_FRAME_BUILDER_CORE_MACROS_SVH
`define CHECKSUMMED_FRAME_BUILDER_CORE_MACROS_SVH

// Check a property while the block is out of reset.
`define CFB_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("frame builder check failed");

// Check a property at every edge, reset included.
`define CFB_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("frame builder reset check failed");

`endif

// File: src/cfb_pkg.sv
// Shared types and constants of the checksummed frame builder.
`timescale 1ns / 1ps

package cfb_pkg;

    localparam int MAX_PAYLOAD = 4096;
    localparam int LEN_W       = 13;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_ADDR_W  = 8;

    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_START_CODE = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_END_CODE   = CFG_ADDR_W'(1);

    localparam logic ACT_HEADER  = 1'b0;
    localparam logic ACT_PAYLOAD = 1'b1;

    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PAYLOAD);

    typedef enum logic {
        KIND_HEADER,
        KIND_PAYLOAD
    } t_kind;

    // One request handed from the front to the back.
    typedef struct packed {
        t_kind             kind;
        logic              last;
        logic [7:0]        data;
        logic [15:0]       command;
        logic [7:0]        device;
        logic [LEN_W-1:0]  length;
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LEN3,
        ST_LEN2,
        ST_LEN1,
        ST_LEN0,
        ST_CMDH,
        ST_CMDL,
        ST_DEV,
        ST_CSH,
        ST_CSL,
        ST_END
    } t_state;

endpackage

// File: src/cfb_front.sv
// Front end: accepts requests, tracks the open frame and queues work.
`timescale 1ns / 1ps

module cfb_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_action,
    input  logic [15:0]                 i_command,
    input  logic [7:0]                  i_device,
    input  logic [cfb_pkg::LEN_W-1:0]   i_length,
    input  logic [7:0]                  i_data,
    input  logic                        i_full,
    output logic                        o_push,
    output cfb_pkg::t_cmd               o_cmd
);

    logic                      r_open;
    logic [cfb_pkg::LEN_W-1:0] r_remain;
    logic                      n_open;
    logic [cfb_pkg::LEN_W-1:0] n_remain;
    logic [cfb_pkg::LEN_W-1:0] w_len;
    logic                      w_accept;

    assign o_ready  = !i_full;
    assign w_accept = i_valid && o_ready;
    assign w_len    = (i_length > cfb_pkg::LEN_MAX) ? cfb_pkg::LEN_MAX : i_length;

    always_comb begin
        n_open          = r_open;
        n_remain        = r_remain;
        o_push          = 1'b0;
        o_cmd.kind      = cfb_pkg::KIND_HEADER;
        o_cmd.last      = 1'b0;
        o_cmd.data      = i_data;
        o_cmd.command   = i_command;
        o_cmd.device    = i_device;
        o_cmd.length    = w_len;
        if (w_accept) begin
            unique case (i_action)
                cfb_pkg::ACT_HEADER: begin
                    // abandon any open frame and restart the count
                    o_push   = 1'b1;
                    n_open   = (w_len != '0);
                    n_remain = w_len;
                end
                cfb_pkg::ACT_PAYLOAD: begin
                    o_cmd.kind = cfb_pkg::KIND_PAYLOAD;
                    o_cmd.last = (r_remain == cfb_pkg::LEN_W'(1));
                    // drop payload with no open frame
                    if (r_open && (r_remain != '0)) begin
                        o_push   = 1'b1;
                        n_remain = r_remain - cfb_pkg::LEN_W'(1);
                        n_open   = (r_remain != cfb_pkg::LEN_W'(1));
                    end
                end
                default: begin
                    o_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open   <= 1'b0;
            r_remain <= '0;
        end else begin
            r_open   <= n_open;
            r_remain <= n_remain;
        end
    end

endmodule

// File: src/cfb_queue.sv
// Short shift queue of requests between front and back.
`timescale 1ns / 1ps

module cfb_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cfb_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output cfb_pkg::t_cmd o_cmd
);

    cfb_pkg::t_cmd              r_q [cfb_pkg::QUEUE_DEPTH];
    logic [cfb_pkg::QCNT_W-1:0] r_count;
    logic [cfb_pkg::QCNT_W-1:0] w_wr_slot;
    logic [cfb_pkg::QPTR_W-1:0] w_wr_idx;

    assign o_full    = (r_count == cfb_pkg::QCNT_W'(cfb_pkg::QUEUE_DEPTH));
    assign o_valid   = (r_count != '0);
    assign o_cmd     = r_q[0];
    assign w_wr_slot = i_pop ? (r_count - cfb_pkg::QCNT_W'(1)) : r_count;
    assign w_wr_idx  = w_wr_slot[cfb_pkg::QPTR_W-1:0];

    // Each entry takes the incoming request or shifts down on a pop.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < cfb_pkg::QUEUE_DEPTH - 1; i++) begin
            if (i_push && (w_wr_idx == cfb_pkg::QPTR_W'(i))) begin
                r_q[i] <= i_cmd;
            end else if (i_pop) begin
                r_q[i] <= r_q[i+1];
            end
        end
        if (i_push && (w_wr_idx == cfb_pkg::QPTR_W'(cfb_pkg::QUEUE_DEPTH - 1))) begin
            r_q[cfb_pkg::QUEUE_DEPTH-1] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= r_count + cfb_pkg::QCNT_W'(i_push) - cfb_pkg::QCNT_W'(i_pop);
        end
    end

endmodule

// File: src/cfb_back.sv
// Back end: serializes queued requests into frame bytes with the checksum.
`timescale 1ns / 1ps

module cfb_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [7:0]    i_start_code,
    input  logic [7:0]    i_end_code,
    input  logic          i_q_valid,
    input  cfb_pkg::t_cmd i_q_cmd,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_byte,
    output logic          o_last
);

    cfb_pkg::t_state           r_state;
    cfb_pkg::t_state           n_state;
    logic [15:0]               r_command;
    logic [7:0]                r_device;
    logic [cfb_pkg::LEN_W-1:0] r_length;
    logic [15:0]               r_sum;
    logic [7:0]                r_pend;
    logic                      r_parity;
    logic                      r_out_valid;
    logic [7:0]                r_out_byte;
    logic                      r_out_last;

    logic        w_free;
    logic        w_emit;
    logic [7:0]  w_byte;
    logic        w_last;
    logic        w_sum_en;
    logic        w_clear;
    logic        w_load;
    logic        w_fin;
    logic [15:0] w_final;

    // ones' complement add with end-around carry
    function automatic logic [15:0] f_oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        f_oc_add = s[15:0] + {15'd0, s[16]};
    endfunction

    assign w_free  = !r_out_valid || i_ready;
    assign w_final = r_parity ? f_oc_add(r_sum, {8'd0, r_pend}) : r_sum;

    always_comb begin
        n_state = r_state;
        if (w_free) begin
            unique case (r_state)
                cfb_pkg::ST_IDLE: begin
                    if (i_q_valid) begin
                        if (i_q_cmd.kind == cfb_pkg::KIND_HEADER) begin
                            n_state = cfb_pkg::ST_LEN3;
                        end else if (i_q_cmd.last) begin
                            n_state = cfb_pkg::ST_CSH;
                        end
                    end
                end
                cfb_pkg::ST_LEN3: n_state = cfb_pkg::ST_LEN2;
                cfb_pkg::ST_LEN2: n_state = cfb_pkg::ST_LEN1;
                cfb_pkg::ST_LEN1: n_state = cfb_pkg::ST_LEN0;
                cfb_pkg::ST_LEN0: n_state = cfb_pkg::ST_CMDH;
                cfb_pkg::ST_CMDH: n_state = cfb_pkg::ST_CMDL;
                cfb_pkg::ST_CMDL: n_state = cfb_pkg::ST_DEV;
                cfb_pkg::ST_DEV: begin
                    n_state = (r_length == '0) ? cfb_pkg::ST_CSH : cfb_pkg::ST_IDLE;
                end
                cfb_pkg::ST_CSH:  n_state = cfb_pkg::ST_CSL;
                cfb_pkg::ST_CSL:  n_state = cfb_pkg::ST_END;
                cfb_pkg::ST_END:  n_state = cfb_pkg::ST_IDLE;
                default:          n_state = cfb_pkg::ST_IDLE;
            endcase
        end
    end

    always_comb begin
        o_pop    = 1'b0;
        w_emit   = w_free;
        w_byte   = 8'd0;
        w_last   = 1'b0;
        w_sum_en = 1'b0;
        w_clear  = 1'b0;
        w_load   = 1'b0;
        w_fin    = 1'b0;
        unique case (r_state)
            cfb_pkg::ST_IDLE: begin
                o_pop  = w_free && i_q_valid;
                w_emit = o_pop;
                if (i_q_cmd.kind == cfb_pkg::KIND_HEADER) begin
                    w_byte  = i_start_code;
                    w_clear = o_pop;
                    w_load  = o_pop;
                end else begin
                    w_byte   = i_q_cmd.data;
                    w_sum_en = o_pop;
                end
            end
            cfb_pkg::ST_LEN3: begin
                w_sum_en = w_free;
            end
            cfb_pkg::ST_LEN2: begin
                w_sum_en = w_free;
            end
            cfb_pkg::ST_LEN1: begin
                w_byte   = 8'(r_length >> 8);
                w_sum_en = w_free;
            end
            cfb_pkg::ST_LEN0: begin
                w_byte   = r_length[7:0];
                w_sum_en = w_free;
            end
            cfb_pkg::ST_CMDH: begin
                w_byte   = r_command[15:8];
                w_sum_en = w_free;
            end
            cfb_pkg::ST_CMDL: begin
                w_byte   = r_command[7:0];
                w_sum_en = w_free;
            end
            cfb_pkg::ST_DEV: begin
                w_byte   = r_device;
                w_sum_en = w_free;
            end
            cfb_pkg::ST_CSH: begin
                w_byte = ~w_final[15:8];
                w_fin  = w_free;
            end
            cfb_pkg::ST_CSL: begin
                w_byte = ~r_sum[7:0];
            end
            cfb_pkg::ST_END: begin
                w_byte  = i_end_code;
                w_last  = 1'b1;
                w_clear = w_free;
            end
            default: begin
                w_emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cfb_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_sum       <= '0;
            r_pend      <= '0;
            r_parity    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_clear) begin
                r_sum    <= '0;
                r_pend   <= '0;
                r_parity <= 1'b0;
            end else if (w_sum_en) begin
                if (!r_parity) begin
                    r_pend   <= w_byte;
                    r_parity <= 1'b1;
                end else begin
                    r_sum    <= f_oc_add(r_sum, {w_byte, r_pend});
                    r_pend   <= '0;
                    r_parity <= 1'b0;
                end
            end else if (w_fin) begin
                r_sum    <= w_final;
                r_pend   <= '0;
                r_parity <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_byte <= w_byte;
            r_out_last <= w_last;
        end
        if (w_load) begin
            r_command <= i_q_cmd.command;
            r_device  <= i_q_cmd.device;
            r_length  <= i_q_cmd.length;
        end
    end

    assign o_valid = r_out_valid;
    assign o_byte  = r_out_byte;
    assign o_last  = r_out_last;

endmodule

// File: src/checksummed_frame_builder_core.sv
// Top level of the checksummed command frame builder.
// Usage:
//   Slave channel (i_s_*): one request per handshake. tuser = action
//   (0 header, 1 payload byte). A header yields start code, 32-bit length,
//   16-bit command and device byte; payload bytes pass through; after the
//   last payload byte (or straight after a zero-length header) come the
//   inverted checksum, high byte first, and the end code with tlast set.
//   Payload with no open frame is dropped. Lengths above 4096 saturate.
//   Master channel (o_m_*): one frame byte per handshake, tlast on end code.
//   Config channel (i_cfg_*): index 0 start code, index 1 end code; always
//   ready; write only while the block is idle.
// Timing:
//   On an idle block an accepted request is registered in the queue and then in
//   the output register before tvalid rises. Payload runs at one byte per cycle
//   while the receiver is ready; a header yields 8 frame bytes (11 with zero
//   length); the last payload byte adds 3 trailer bytes.
//   A 4-entry request queue between front and back absorbs header bursts;
//   tready drops when it is full.
// Reset clears frame state, the queue and both config registers. A stalled
// receiver holds the output byte; the queue keeps accepting until full.
`timescale 1ns / 1ps

module checksummed_frame_builder_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // [15:0] command_code, [23:16] device_number, [36:24] payload_length,
    // [44:37] data_byte, [47:45] zero
    input  logic [47:0]                      i_s_tdata,
    // [0] action
    input  logic                             i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [7:0] out_byte
    output logic [7:0]                       o_m_tdata,
    output logic                             o_m_tlast,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [cfb_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [7:0]                       i_cfg_data
);

    logic [7:0]    r_start_code;
    logic [7:0]    r_end_code;
    logic          w_push;
    logic          w_full;
    logic          w_pop;
    logic          w_q_valid;
    cfb_pkg::t_cmd w_push_cmd;
    cfb_pkg::t_cmd w_q_cmd;

    // Config writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_code <= 8'd0;
            r_end_code   <= 8'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_addr)
                cfb_pkg::CFG_IDX_START_CODE: r_start_code <= i_cfg_data;
                cfb_pkg::CFG_IDX_END_CODE:   r_end_code   <= i_cfg_data;
                default: begin
                    // drop writes to unknown registers
                end
            endcase
        end
    end

    // Front: classify requests and track the payload count.
    cfb_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_action  (i_s_tuser),
        .i_command (i_s_tdata[15:0]),
        .i_device  (i_s_tdata[23:16]),
        .i_length  (i_s_tdata[36:24]),
        .i_data    (i_s_tdata[44:37]),
        .i_full    (w_full),
        .o_push    (w_push),
        .o_cmd     (w_push_cmd)
    );

    // Queue: decouple request intake from byte serialization.
    cfb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    // Back: emit frame bytes and fold the checksum.
    cfb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start_code (r_start_code),
        .i_end_code   (r_end_code),
        .i_q_valid    (w_q_valid),
        .i_q_cmd      (w_q_cmd),
        .o_pop        (w_pop),
        .o_valid      (o_m_tvalid),
        .i_ready      (i_m_tready),
        .o_byte       (o_m_tdata),
        .o_last       (o_m_tlast)
    );

endmodule

// File: src/cfb_checker.sv
// Port-level checker for the frame builder, bound to the top level.
`timescale 1ns / 1ps
`include "checksummed_frame_builder_core_macros.svh"

module cfb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_tvalid,
    input logic       o_s_tready,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata,
    input logic       o_m_tlast
);

    logic [8:0] w_out;

    assign w_out = {o_m_tdata, o_m_tlast};

    // A stalled output byte holds.
    `CFB_ASSERT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(w_out))

    // Reset empties the output register.
    `CFB_ASSERT_ALWAYS(a_rst_out_idle, i_clk, !i_rst_n |=> !o_m_tvalid)

    // Reset empties the request queue.
    `CFB_ASSERT_ALWAYS(a_rst_in_ready, i_clk, !i_rst_n |=> o_s_tready)

    // The queue fills only on an accepted request.
    `CFB_ASSERT(a_full_on_push, i_clk, i_rst_n, $fell(o_s_tready) |-> $past(i_s_tvalid && o_s_tready))

endmodule

bind checksummed_frame_builder_core cfb_checker u_cfb_checker (.*);
